// ===== design/keyframe_playback_sequencer_unit_defines.svh =====
// Assertion macros shared by the sequencer RTL.
// Each use expects clk and arst_n in scope.
`ifndef KEYFRAME_PLAYBACK_SEQUENCER_UNIT_DEFINES_SVH
`define KEYFRAME_PLAYBACK_SEQUENCER_UNIT_DEFINES_SVH

// property that must hold at every edge out of reset
`define KPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// antecedent in one cycle implies consequent in the next
`define KPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/kps_pkg.sv =====
`default_nettype none
package kps_pkg;
	localparam int DUR_W     = 16;
	localparam int FRAME_W   = 16;
	localparam int EVENT_W   = 8;
	localparam int DELTA_W   = 16;
	localparam int IDX_W     = 6;
	localparam int COUNT_W   = 7;
	localparam int ELAPSED_W = 24;
	// 127 entries of at most 65535 units each
	localparam int SUM_W     = 23;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	localparam logic REG_LOOP_ENABLE = 1'b0;
	localparam logic REG_ENTRY_COUNT = 1'b1;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_START = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_STOP  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic               loop_enable;
		logic [COUNT_W-1:0] entry_count;
		logic               count_upd;
	} cfg_t;
endpackage
`default_nettype wire

// ===== design/kps_ram.sv =====
`default_nettype none
module kps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== design/kps_rem.sv =====
`default_nettype none
// Restoring remainder, one quotient bit per cycle.
module kps_rem import kps_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [ELAPSED_W-1:0] dividend,
	input  wire logic [SUM_W-1:0]     divisor,
	output logic                      busy,
	output logic                      done,
	output logic      [SUM_W-1:0]     rem
);
	localparam int CNT_W = $clog2(ELAPSED_W + 1);

	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [ELAPSED_W-1:0] dvd_q;
	logic [SUM_W-1:0]     div_q;
	logic [SUM_W-1:0]     rem_q;
	logic [SUM_W:0]       trial;
	logic                 ge;

	assign trial = {rem_q, dvd_q[ELAPSED_W-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ELAPSED_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ELAPSED_W-2:0], 1'b0};
			// partial remainder stays below the divisor, so it fits SUM_W
			rem_q <= ge ? SUM_W'(trial - {1'b0, div_q}) : SUM_W'(trial);
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

// ===== design/kps_regs.sv =====
`default_nettype none
module kps_regs import kps_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg
);
	logic               loop_q;
	logic [COUNT_W-1:0] count_q;
	logic               wr;
	logic               sel;

	assign wr     = psel & penable & pwrite;
	assign sel    = paddr[2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_q  <= 1'b0;
			count_q <= COUNT_W'(1);
		end else if (wr) begin
			case (sel)
				REG_LOOP_ENABLE: loop_q  <= pwdata[0];
				REG_ENTRY_COUNT: count_q <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_LOOP_ENABLE: prdata = {{(PDATA_W-1){1'b0}}, loop_q};
			REG_ENTRY_COUNT: prdata = {{(PDATA_W-COUNT_W){1'b0}}, count_q};
			default:         prdata = '0;
		endcase
	end

	assign cfg.loop_enable = loop_q;
	assign cfg.entry_count = count_q;
	assign cfg.count_upd   = wr && (sel == REG_ENTRY_COUNT);
endmodule
`default_nettype wire

// ===== design/kps_ctrl.sv =====
`default_nettype none
`include "keyframe_playback_sequencer_unit_defines.svh"
module kps_ctrl import kps_pkg::*; #(
	parameter int MAX_ENTRIES = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         cmd,
	input  wire logic [IDX_W-1:0]   entry_index,
	input  wire logic [DUR_W-1:0]   entry_duration,
	input  wire logic [FRAME_W-1:0] entry_frame,
	input  wire logic [EVENT_W-1:0] entry_event,
	input  wire logic [DELTA_W-1:0] delta,
	output logic                    done,
	output logic      [FRAME_W-1:0] frame_number,
	output logic      [EVENT_W-1:0] event_flags,
	output logic      [IDX_W-1:0]   position,
	output logic                    is_playing,
	output logic                    is_finished
);
	localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int NW   = AW + 1;
	localparam int DF_W = DUR_W + FRAME_W;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_SUM,
		ST_CHK,
		ST_DIV,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_RD
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        cur_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic                 playing_q;
	logic                 finished_q;
	logic                 started_q;
	logic                 done_q;
	logic                 first_q;
	logic [AW-1:0]        clr_q;
	// cached table length over the active entries
	logic                 sum_ok_q;
	logic [SUM_W-1:0]     sum_q;
	logic                 zero_q;
	logic [NW-1:0]        iss_q;
	logic                 sweep_v_s1;

	cmd_t                 cmd_q;
	logic [IDX_W-1:0]     idx_q;
	logic [DUR_W-1:0]     dur_in_q;
	logic [FRAME_W-1:0]   frame_in_q;
	logic [EVENT_W-1:0]   event_in_q;
	logic [DELTA_W-1:0]   delta_q;

	logic [NW-1:0]        n_act;
	logic [NW-1:0]        nxt;
	logic                 idx_ok;
	logic [ELAPSED_W:0]   el_add;
	logic [ELAPSED_W-1:0] el_sat;
	logic                 mod_need;
	logic [DUR_W-1:0]     dur_rd;

	logic                 df_we;
	logic [AW-1:0]        raddr;
	logic [DF_W-1:0]      df_rdata;
	logic                 ev_we;
	logic [AW-1:0]        ev_waddr;
	logic [EVENT_W-1:0]   ev_wdata;
	logic [EVENT_W-1:0]   ev_rdata;

	logic                 rem_start;
	logic                 rem_busy;
	logic                 rem_done;
	logic [SUM_W-1:0]     rem_val;

	always_comb begin
		if (cfg.entry_count == '0) begin
			n_act = NW'(1);
		end else if (32'(cfg.entry_count) > MAX_ENTRIES) begin
			n_act = NW'(MAX_ENTRIES);
		end else begin
			n_act = NW'(cfg.entry_count);
		end
	end

	assign nxt      = {1'b0, cur_q} + NW'(1);
	assign idx_ok   = 32'(idx_q) < MAX_ENTRIES;
	assign el_add   = {1'b0, elapsed_q} + (ELAPSED_W+1)'(delta_q);
	assign el_sat   = el_add[ELAPSED_W] ? ELAPSED_MAX : el_add[ELAPSED_W-1:0];
	assign dur_rd   = df_rdata[DF_W-1:FRAME_W];
	// whole laps of the table drop out by a remainder when all durations are nonzero
	assign mod_need = !zero_q && ({1'b0, cur_q} < n_act) && (sum_q != '0)
		&& (elapsed_q >= {1'b0, sum_q});

	assign df_we    = (state_q == ST_EXEC) && (cmd_q == CMD_WRITE) && idx_ok;
	assign raddr    = (state_q == ST_SUM) ? iss_q[AW-1:0] : cur_q;
	assign ev_we    = (state_q == ST_CLEAR) || df_we;
	assign ev_waddr = (state_q == ST_CLEAR) ? clr_q : AW'(idx_q);
	assign ev_wdata = (state_q == ST_CLEAR) ? '0 : event_in_q;
	assign rem_start = (state_q == ST_CHK) && mod_need;

	kps_ram #(
		.WIDTH(DF_W),
		.DEPTH(MAX_ENTRIES)
	) u_df_ram (
		.clk  (clk),
		.we   (df_we),
		.waddr(AW'(idx_q)),
		.wdata({dur_in_q, frame_in_q}),
		.raddr(raddr),
		.rdata(df_rdata)
	);

	kps_ram #(
		.WIDTH(EVENT_W),
		.DEPTH(MAX_ENTRIES)
	) u_ev_ram (
		.clk  (clk),
		.we   (ev_we),
		.waddr(ev_waddr),
		.wdata(ev_wdata),
		.raddr(raddr),
		.rdata(ev_rdata)
	);

	kps_rem u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rem_start),
		.dividend(elapsed_q),
		.divisor (sum_q),
		.busy    (rem_busy),
		.done    (rem_done),
		.rem     (rem_val)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q      <= cmd_t'(cmd);
			idx_q      <= entry_index;
			dur_in_q   <= entry_duration;
			frame_in_q <= entry_frame;
			event_in_q <= entry_event;
			delta_q    <= delta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			cur_q      <= '0;
			elapsed_q  <= '0;
			playing_q  <= 1'b0;
			finished_q <= 1'b0;
			started_q  <= 1'b0;
			done_q     <= 1'b0;
			first_q    <= 1'b0;
			clr_q      <= '0;
			sum_ok_q   <= 1'b0;
			sum_q      <= '0;
			zero_q     <= 1'b0;
			iss_q      <= '0;
			sweep_v_s1 <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_RD;
					case (cmd_q)
						CMD_WRITE: sum_ok_q <= 1'b0;
						CMD_START: begin
							cur_q      <= '0;
							elapsed_q  <= '0;
							playing_q  <= 1'b1;
							finished_q <= 1'b0;
							started_q  <= 1'b1;
						end
						CMD_TICK: begin
							if (playing_q && !finished_q) begin
								elapsed_q <= el_sat;
								first_q   <= 1'b1;
								if (!cfg.loop_enable) begin
									state_q <= ST_WALK_RD;
								end else if (sum_ok_q) begin
									state_q <= ST_CHK;
								end else begin
									iss_q      <= '0;
									sum_q      <= '0;
									zero_q     <= 1'b0;
									sweep_v_s1 <= 1'b0;
									state_q    <= ST_SUM;
								end
							end
						end
						CMD_STOP: playing_q <= 1'b0;
						default: ;
					endcase
				end
				ST_SUM: begin
					if (iss_q != n_act) begin
						iss_q <= iss_q + NW'(1);
					end
					sweep_v_s1 <= (iss_q != n_act);
					if (sweep_v_s1) begin
						sum_q <= sum_q + SUM_W'(dur_rd);
						if (dur_rd == '0) begin
							zero_q <= 1'b1;
						end
					end
					if (iss_q == n_act && !sweep_v_s1) begin
						sum_ok_q <= 1'b1;
						state_q  <= ST_CHK;
					end
				end
				ST_CHK: begin
					state_q <= mod_need ? ST_DIV : ST_WALK_RD;
				end
				ST_DIV: begin
					if (rem_done) begin
						elapsed_q <= ELAPSED_W'(rem_val);
						state_q   <= ST_WALK_RD;
					end
				end
				ST_WALK_RD: begin
					state_q <= ST_WALK_CHK;
				end
				ST_WALK_CHK: begin
					// first pass steps even over a zero duration; later ones stop on it
					if (!first_q && dur_rd == '0) begin
						state_q <= ST_RD;
					end else if (elapsed_q >= ELAPSED_W'(dur_rd)) begin
						first_q <= 1'b0;
						if (nxt >= n_act) begin
							if (cfg.loop_enable) begin
								cur_q     <= '0;
								elapsed_q <= elapsed_q - ELAPSED_W'(dur_rd);
								state_q   <= ST_WALK_RD;
							end else begin
								cur_q      <= AW'(n_act - NW'(1));
								playing_q  <= 1'b0;
								finished_q <= 1'b1;
								elapsed_q  <= '0;
								state_q    <= ST_RD;
							end
						end else begin
							cur_q     <= AW'(nxt);
							elapsed_q <= elapsed_q - ELAPSED_W'(dur_rd);
							state_q   <= ST_WALK_RD;
						end
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cfg.count_upd) begin
				sum_ok_q <= 1'b0;
			end
		end
	end

	assign busy         = state_q != ST_IDLE;
	assign done         = done_q;
	assign frame_number = started_q ? df_rdata[FRAME_W-1:0] : '0;
	assign event_flags  = started_q ? ev_rdata : '0;
	assign position     = IDX_W'(cur_q);
	assign is_playing   = playing_q;
	assign is_finished  = finished_q;

	`KPS_ASSERT(a_fin_stops, finished_q |-> !playing_q, "finished while still playing")
	`KPS_ASSERT_NEXT(a_rd_strobe, state_q == ST_RD, done_q && state_q == ST_IDLE, "missing result strobe")
	`KPS_ASSERT_NEXT(a_done_single, done_q, !done_q, "result strobe longer than one cycle")
	`KPS_ASSERT(a_rem_bound, (state_q == ST_DIV && rem_done) |-> (rem_val < sum_q), "remainder not below table length")
	`KPS_ASSERT(a_idle_rem, (state_q == ST_IDLE) |-> !rem_busy, "remainder unit busy while idle")
endmodule
`default_nettype wire

// ===== design/keyframe_playback_sequencer_unit.sv =====
`default_nettype none
// channel  | signals                                           | handshake
// ---------+---------------------------------------------------+------------------------
// cmd in   | cmd entry_index entry_duration entry_frame        | start && !busy
//          | entry_event delta                                 |
// result   | frame_number event_flags position is_playing      | done, one cycle
//          | is_finished                                       |
// config   | psel penable pwrite paddr pwdata prdata pready    | psel&penable&pwrite
//
// Write, start, stop, idle tick: EXEC then RD, which raises the strobe; the next item waits for IDLE.
// Playing tick: EXEC, then WALK_RD and WALK_CHK for each entry walked, then RD; CHK too when looping.
// Looping after a table write or entry_count change: the SUM state first re-sums the n durations.
// A timer past one lap goes through DIV and the remainder unit; past entry_count it walks per entry.
// After reset busy stays high while the CLEAR state clears the event memory.
// The receiver cannot stall; results are never held back.
module keyframe_playback_sequencer_unit import kps_pkg::*; #(
	parameter int MAX_ENTRIES = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         cmd,
	input  wire logic [IDX_W-1:0]   entry_index,
	input  wire logic [DUR_W-1:0]   entry_duration,
	input  wire logic [FRAME_W-1:0] entry_frame,
	input  wire logic [EVENT_W-1:0] entry_event,
	input  wire logic [DELTA_W-1:0] delta,
	output logic                    done,
	output logic      [FRAME_W-1:0] frame_number,
	output logic      [EVENT_W-1:0] event_flags,
	output logic      [IDX_W-1:0]   position,
	output logic                    is_playing,
	output logic                    is_finished
);
	cfg_t cfg;

	kps_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	kps_ctrl #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.entry_index   (entry_index),
		.entry_duration(entry_duration),
		.entry_frame   (entry_frame),
		.entry_event   (entry_event),
		.delta         (delta),
		.done          (done),
		.frame_number  (frame_number),
		.event_flags   (event_flags),
		.position      (position),
		.is_playing    (is_playing),
		.is_finished   (is_finished)
	);
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
module tb;
	import kps_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int CYCLE_LIMIT = 3000000;
	localparam logic [PADDR_W-1:0] ADDR_LOOP  = PADDR_W'({REG_LOOP_ENABLE, 2'b00});
	localparam logic [PADDR_W-1:0] ADDR_COUNT = PADDR_W'({REG_ENTRY_COUNT, 2'b00});

	typedef struct {
		cmd_t               op;
		logic [IDX_W-1:0]   idx;
		logic [DUR_W-1:0]   dur;
		logic [FRAME_W-1:0] frm;
		logic [EVENT_W-1:0] evt;
		logic [DELTA_W-1:0] dt;
	} seq_cmd_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic [EVENT_W-1:0] flags;
		logic [IDX_W-1:0]   pos;
		logic               play;
		logic               fin;
	} status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic [1:0] cmd = '0;
	logic [IDX_W-1:0] entry_index = '0;
	logic [DUR_W-1:0] entry_duration = '0;
	logic [FRAME_W-1:0] entry_frame = '0;
	logic [EVENT_W-1:0] entry_event = '0;
	logic [DELTA_W-1:0] delta = '0;
	logic done;
	logic [FRAME_W-1:0] frame_number;
	logic [EVENT_W-1:0] event_flags;
	logic [IDX_W-1:0] position;
	logic is_playing;
	logic is_finished;

	keyframe_playback_sequencer_unit #(.MAX_ENTRIES(TABLE_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.cmd(cmd), .entry_index(entry_index), .entry_duration(entry_duration),
		.entry_frame(entry_frame), .entry_event(entry_event), .delta(delta),
		.done(done), .frame_number(frame_number), .event_flags(event_flags),
		.position(position), .is_playing(is_playing), .is_finished(is_finished)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// sequencer shadow state
	logic [DUR_W-1:0]   dur_tab [TABLE_DEPTH];
	logic [FRAME_W-1:0] frm_tab [TABLE_DEPTH];
	logic [EVENT_W-1:0] evt_tab [TABLE_DEPTH];
	int unsigned cur_pos = 0;
	int unsigned timer_units = 0;
	bit playing = 1'b0;
	bit finished = 1'b0;
	bit started = 1'b0;
	bit loop_on = 1'b0;
	int unsigned count_reg = 1;

	seq_cmd_t pending_cmds [$];
	status_t expected_status [$];
	seq_cmd_t in_flight;
	status_t got_status;
	status_t want_status;
	int idle_pct = 24;
	int mismatches = 0;
	int unsigned cycle_count = 0;

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++)
			evt_tab[i] = '0;
	end

	function automatic void advance_timer(int unsigned dt);
		int unsigned n;
		int unsigned lap;
		int unsigned d;
		bit has_zero;
		n = (count_reg == 0) ? 1 : ((count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg);
		if (!playing || finished)
			return;
		timer_units += dt;
		if (timer_units > ELAPSED_MAX)
			timer_units = ELAPSED_MAX;
		if (loop_on) begin
			lap = 0;
			has_zero = 1'b0;
			for (int i = 0; i < n; i++) begin
				if (dur_tab[i] == 0)
					has_zero = 1'b1;
				lap += dur_tab[i];
			end
			// whole laps drop out when every duration is nonzero
			if (!has_zero && cur_pos < n && lap != 0 && timer_units >= lap)
				timer_units = timer_units % lap;
		end
		d = dur_tab[cur_pos % TABLE_DEPTH];
		while (timer_units >= d) begin
			timer_units -= d;
			cur_pos++;
			if (cur_pos >= n) begin
				if (loop_on) begin
					cur_pos = 0;
				end else begin
					cur_pos = n - 1;
					playing = 1'b0;
					finished = 1'b1;
					timer_units = 0;
					return;
				end
			end
			d = dur_tab[cur_pos % TABLE_DEPTH];
			if (d == 0)
				break;
		end
	endfunction

	function automatic status_t apply_command(seq_cmd_t c);
		status_t s;
		int unsigned slot;
		case (c.op)
			CMD_WRITE: begin
				dur_tab[c.idx] = c.dur;
				frm_tab[c.idx] = c.frm;
				evt_tab[c.idx] = c.evt;
			end
			CMD_START: begin
				cur_pos = 0;
				timer_units = 0;
				playing = 1'b1;
				finished = 1'b0;
				started = 1'b1;
			end
			CMD_TICK: advance_timer(c.dt);
			default: playing = 1'b0;
		endcase
		slot = cur_pos % TABLE_DEPTH;
		s.frame = started ? frm_tab[slot] : '0;
		s.flags = started ? evt_tab[slot] : '0;
		s.pos = IDX_W'(cur_pos);
		s.play = playing;
		s.fin = finished;
		return s;
	endfunction

	// driver: predicts at the accepting edge, then offers the next item
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				expected_status.push_back(apply_command(in_flight));
			if (!start || !busy) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
					in_flight = pending_cmds.pop_front();
					cmd <= in_flight.op;
					entry_index <= in_flight.idx;
					entry_duration <= in_flight.dur;
					entry_frame <= in_flight.frm;
					entry_event <= in_flight.evt;
					delta <= in_flight.dt;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			got_status = '{frame_number, event_flags, position, is_playing, is_finished};
			if (expected_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: frame %0d flags %0h pos %0d play %b fin %b",
						frame_number, event_flags, position, is_playing, is_finished);
			end else begin
				want_status = expected_status.pop_front();
				if (got_status !== want_status) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: frame %0d/%0d flags %0h/%0h pos %0d/%0d ",
							"play %b/%b fin %b/%b (expected/actual)"},
							want_status.frame, got_status.frame,
							want_status.flags, got_status.flags,
							want_status.pos, got_status.pos,
							want_status.play, got_status.play,
							want_status.fin, got_status.fin);
				end
			end
		end
	end

	task automatic push_ctrl(cmd_t op, int unsigned dt);
		seq_cmd_t c;
		c.op = op;
		c.idx = IDX_W'($urandom);
		c.dur = DUR_W'($urandom);
		c.frm = FRAME_W'($urandom);
		c.evt = EVENT_W'($urandom);
		c.dt = DELTA_W'(dt);
		pending_cmds.push_back(c);
	endtask

	task automatic push_write(int unsigned idx, int unsigned dur, int unsigned frm,
			int unsigned evt);
		seq_cmd_t c;
		c.op = CMD_WRITE;
		c.idx = IDX_W'(idx);
		c.dur = DUR_W'(dur);
		c.frm = FRAME_W'(frm);
		c.evt = EVENT_W'(evt);
		c.dt = DELTA_W'($urandom);
		pending_cmds.push_back(c);
	endtask

	// wait until the block has nothing queued, in flight or owed
	task automatic drain();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || start || expected_status.size() != 0
			|| busy !== 1'b0);
		repeat (4) @(negedge clk);
	endtask

	task automatic reg_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_regs(bit lp, int unsigned count);
		logic [PDATA_W-1:0] data;
		drain();
		// junk in the unused upper bits
		data = ($urandom & 32'hFFFF_FFFE) | lp;
		reg_write(ADDR_LOOP, data);
		loop_on = data[0];
		data = ($urandom & 32'hFFFF_FF80) | (count & 32'h7F);
		reg_write(ADDR_COUNT, data);
		count_reg = data[6:0];
	endtask

	task automatic random_burst(int items);
		int unsigned r;
		int unsigned dt;
		int unsigned dur;
		for (int k = 0; k < items; k++) begin
			r = $urandom_range(99);
			if (r < 68) begin
				r = $urandom_range(99);
				if (r < 10)
					dt = 0;
				else if (r < 15)
					dt = 16'hFFFF;
				else if (r < 30)
					dt = $urandom_range(65535);
				else
					dt = $urandom_range(3000);
				push_ctrl(CMD_TICK, dt);
			end else if (r < 80) begin
				r = $urandom_range(99);
				if (r < 10)
					dur = 0;
				else if (r < 20)
					dur = $urandom_range(65535, 16);
				else
					dur = $urandom_range(4095, 16);
				push_write($urandom_range(63), dur, $urandom_range(65535),
					($urandom_range(99) < 30) ? 0 : $urandom_range(255));
			end else if (r < 92) begin
				push_ctrl(CMD_START, $urandom);
			end else begin
				push_ctrl(CMD_STOP, $urandom);
			end
		end
	endtask

	initial begin
		int unsigned dur;
		int unsigned count_picks [10];
		int unsigned count;
		count_picks = '{0, 1, 2, 3, 5, 16, 63, 64, 65, 127};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		set_regs(1'b0, 127);
		// nothing started yet: ticks and stops change nothing
		push_ctrl(CMD_TICK, 500);
		push_ctrl(CMD_STOP, $urandom);
		// whole table is loaded before any start so no entry is read unwritten
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			dur = 200 + 13 * i;
			if (i == 2)
				dur = 0;
			else if (i == 3)
				dur = 1;
			else if (i == 63)
				dur = 16'hFFFF;
			if (i == 0)
				push_write(i, dur, 0, 0);
			else if (i == 63)
				push_write(i, dur, 16'hFFFF, 8'hFF);
			else
				push_write(i, dur, $urandom_range(65535),
					(i % 4 == 1) ? 0 : $urandom_range(255));
		end
		push_ctrl(CMD_START, $urandom);
		push_ctrl(CMD_TICK, 0);
		push_ctrl(CMD_TICK, 16'hFFFF);   // stops on the zero-duration entry
		push_ctrl(CMD_TICK, 0);          // zero-duration entry steps on
		push_ctrl(CMD_TICK, 16'hFFFF);   // runs off the end and finishes
		push_ctrl(CMD_TICK, 100);
		push_ctrl(CMD_START, $urandom);
		push_ctrl(CMD_STOP, $urandom);
		push_ctrl(CMD_TICK, 5000);
		push_ctrl(CMD_START, $urandom);

		// count zero acts as one; single-entry wrap
		set_regs(1'b1, 0);
		push_ctrl(CMD_TICK, 16'hFFFF);
		push_ctrl(CMD_TICK, 16'hFFFF);

		// play past entry 4, then shrink the count under the position
		set_regs(1'b1, 64);
		push_ctrl(CMD_START, $urandom);
		push_ctrl(CMD_TICK, 3000);
		push_ctrl(CMD_TICK, 0);
		set_regs(1'b1, 4);
		push_ctrl(CMD_TICK, 500);
		push_ctrl(CMD_TICK, 16'hFFFF);
		push_ctrl(CMD_TICK, 1234);

		// two zero-duration entries in a loop never consume time: timer saturates
		set_regs(1'b1, 2);
		push_write(0, 0, $urandom_range(65535), $urandom_range(255));
		push_write(1, 0, $urandom_range(65535), $urandom_range(255));
		push_ctrl(CMD_START, $urandom);
		repeat (260) push_ctrl(CMD_TICK, 16'hFFFF);
		push_write(0, 5, $urandom_range(65535), $urandom_range(255));
		push_write(1, 7, $urandom_range(65535), $urandom_range(255));
		push_ctrl(CMD_TICK, 0);
		push_ctrl(CMD_TICK, 16'hFFFF);

		for (int mode = 0; mode < 3; mode++) begin
			drain();
			idle_pct = (mode == 0) ? 24 : ((mode == 1) ? 82 : 0);
			repeat (4) begin
				count = $urandom_range(10);
				count = (count == 10) ? $urandom_range(127) : count_picks[count];
				set_regs($urandom_range(1), count);
				// restart so the position never sits beyond a lowered count
				push_ctrl(CMD_START, $urandom);
				random_burst(36);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_status.size() == 0)
			$display("[keyframe_playback_sequencer_unit] OK");
		else
			$display("[keyframe_playback_sequencer_unit] ERROR");
		$finish;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[keyframe_playback_sequencer_unit] ERROR");
		$finish;
	end
endmodule
